>>> sv/rti_pkg.sv
// Shared constants, reason codes and the tag type of the ray/triangle intersection block.
package rti_pkg;

  localparam int COORD_BITS_DEF  = 20;
  localparam int FRAC_BITS_DEF   = 10;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int BARY_SHIFT      = 16;
  localparam int BARY_BITS       = 17;
  localparam int EPS_BITS        = 32;
  localparam int REASON_BITS     = 3;

  localparam logic [EPS_BITS-1:0] EPS_RESET = 32'd1;

  localparam logic [REASON_BITS-1:0] RSN_HIT      = 3'd0;
  localparam logic [REASON_BITS-1:0] RSN_PARALLEL = 3'd1;
  localparam logic [REASON_BITS-1:0] RSN_U_OUT    = 3'd2;
  localparam logic [REASON_BITS-1:0] RSN_V_OUT    = 3'd3;
  localparam logic [REASON_BITS-1:0] RSN_T_OUT    = 3'd4;

  typedef struct packed {
    logic [REASON_BITS-1:0] reason;
    logic                   t_neg;
  } rti_tag_t;

endpackage

>>> sv/rti_front.sv
// Front pipeline: edges, cross and dot products, determinant test and range classification.
module rti_front #(
  parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [3*COORD_BITS-1:0]           ray_origin,
  input  logic [3*COORD_BITS-1:0]           ray_direction,
  input  logic signed [COORD_BITS-1:0]      t_lower,
  input  logic signed [COORD_BITS-1:0]      t_upper,
  input  logic [3*COORD_BITS-1:0]           vertex_a,
  input  logic [3*COORD_BITS-1:0]           vertex_b,
  input  logic [3*COORD_BITS-1:0]           vertex_c,
  input  logic [rti_pkg::EPS_BITS-1:0]      det_eps,
  output logic                              push_valid,
  output rti_pkg::rti_tag_t                 push_tag,
  output logic [3*COORD_BITS+2:0]           push_det,
  output logic [3*COORD_BITS+2:0]           push_tmag,
  output logic [3*COORD_BITS+2:0]           push_nu,
  output logic [3*COORD_BITS+2:0]           push_nv
);

  localparam int C  = COORD_BITS;
  localparam int EW = C + 1;
  localparam int PW = 2 * EW;
  localparam int XW = 2 * C + 3;
  localparam int LW = C + 2;
  localparam int HW = XW - LW;
  localparam int DW = 3 * C + 4;
  localparam int DB = DW - 1;
  localparam int DL = DB / 2;
  localparam int DH = DB - DL;
  localparam int CW = 4 * C + FRAC_BITS + 4;

  // stage 1: edges
  logic                 v1_r;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] tv_r [3];
  logic signed [EW-1:0] d1_r [3];
  logic signed [C-1:0]  tl1_r, tu1_r;

  logic signed [EW-1:0] e1_nxt [3];
  logic signed [EW-1:0] e2_nxt [3];
  logic signed [EW-1:0] tv_nxt [3];
  logic signed [EW-1:0] d1_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = EW'(signed'(vertex_b[i*C +: C])) - EW'(signed'(vertex_a[i*C +: C]));
      e2_nxt[i] = EW'(signed'(vertex_c[i*C +: C])) - EW'(signed'(vertex_a[i*C +: C]));
      tv_nxt[i] = EW'(signed'(ray_origin[i*C +: C])) - EW'(signed'(vertex_a[i*C +: C]));
      d1_nxt[i] = EW'(signed'(ray_direction[i*C +: C]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    e1_r  <= e1_nxt;
    e2_r  <= e2_nxt;
    tv_r  <= tv_nxt;
    d1_r  <= d1_nxt;
    tl1_r <= t_lower;
    tu1_r <= t_upper;
  end

  // stage 2: cross products
  logic                 v2_r;
  logic signed [XW-1:0] pv_r [3];
  logic signed [XW-1:0] qv_r [3];
  logic signed [EW-1:0] e1b_r [3];
  logic signed [EW-1:0] e2b_r [3];
  logic signed [EW-1:0] tvb_r [3];
  logic signed [EW-1:0] d2_r [3];
  logic signed [C-1:0]  tl2_r, tu2_r;

  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  logic signed [PW-1:0] qa [3];
  logic signed [PW-1:0] qb [3];
  logic signed [XW-1:0] pv_nxt [3];
  logic signed [XW-1:0] qv_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i]     = e2_r[(i+1)%3] * d1_r[(i+2)%3];
      pb[i]     = e2_r[(i+2)%3] * d1_r[(i+1)%3];
      qa[i]     = e1_r[(i+1)%3] * tv_r[(i+2)%3];
      qb[i]     = e1_r[(i+2)%3] * tv_r[(i+1)%3];
      pv_nxt[i] = XW'(pa[i]) - XW'(pb[i]);
      qv_nxt[i] = XW'(qa[i]) - XW'(qb[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    pv_r  <= pv_nxt;
    qv_r  <= qv_nxt;
    e1b_r <= e1_r;
    e2b_r <= e2_r;
    tvb_r <= tv_r;
    d2_r  <= d1_r;
    tl2_r <= tl1_r;
    tu2_r <= tu1_r;
  end

  // stage 3: dot product partials (det, nu, nv, nt)
  logic                         v3_r;
  logic signed [EW+LW:0]        lo_r [4][3];
  logic signed [EW+HW-1:0]      hi_r [4][3];
  logic signed [C-1:0]          tl3_r, tu3_r;

  logic signed [EW-1:0]   da [4][3];
  logic signed [XW-1:0]   db [4][3];
  logic signed [EW+LW:0]  lo_nxt [4][3];
  logic signed [EW+HW-1:0] hi_nxt [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da[0][i] = e1b_r[i]; db[0][i] = pv_r[i];
      da[1][i] = tvb_r[i]; db[1][i] = pv_r[i];
      da[2][i] = d2_r[i];  db[2][i] = qv_r[i];
      da[3][i] = e2b_r[i]; db[3][i] = qv_r[i];
    end
    for (int g = 0; g < 4; g++) begin
      for (int i = 0; i < 3; i++) begin
        lo_nxt[g][i] = da[g][i] * signed'({1'b0, db[g][i][LW-1:0]});
        hi_nxt[g][i] = da[g][i] * signed'(db[g][i][XW-1:LW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    tl3_r <= tl2_r;
    tu3_r <= tu2_r;
  end

  // stage 4: dot sums
  logic                 v4_r;
  logic signed [DW-1:0] dot_r [4];
  logic signed [C-1:0]  tl4_r, tu4_r;
  logic signed [DW-1:0] dot_nxt [4];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      dot_nxt[g] = '0;
      for (int i = 0; i < 3; i++) begin
        dot_nxt[g] = dot_nxt[g] + (DW'(hi_r[g][i]) <<< LW) + DW'(lo_r[g][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    dot_r <= dot_nxt;
    tl4_r <= tl3_r;
    tu4_r <= tu3_r;
  end

  // stage 5: parallel test, fold sign of det
  logic                 v5_r, par5_r;
  logic signed [DW-1:0] det5_r, nu5_r, nv5_r, nt5_r;
  logic signed [C-1:0]  tl5_r, tu5_r;

  logic signed [DW-1:0] eps_s;
  logic                 par_nxt, neg;

  always_comb begin
    eps_s   = signed'(DW'(det_eps));
    par_nxt = (dot_r[0] == '0) || ((dot_r[0] > -eps_s) && (dot_r[0] < eps_s));
    neg     = dot_r[0][DW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    par5_r <= par_nxt;
    det5_r <= neg ? -dot_r[0] : dot_r[0];
    nu5_r  <= neg ? -dot_r[1] : dot_r[1];
    nv5_r  <= neg ? -dot_r[2] : dot_r[2];
    nt5_r  <= neg ? -dot_r[3] : dot_r[3];
    tl5_r  <= tl4_r;
    tu5_r  <= tu4_r;
  end

  // stage 6: u and v tests, window bound products
  logic                   v6_r, par6_r, ubad6_r, vbad6_r;
  logic signed [DW-1:0]   nt6_r;
  logic [DB-1:0]          det6_r, nu6_r, nv6_r;
  logic signed [C+DL:0]   tll_r, tul_r;
  logic signed [C+DH:0]   tlh_r, tuh_r;

  logic signed [DW:0] uv_sum;
  logic               ubad_nxt, vbad_nxt;

  always_comb begin
    uv_sum   = (DW+1)'(nu5_r) + (DW+1)'(nv5_r);
    ubad_nxt = nu5_r[DW-1] || (det5_r < nu5_r);
    vbad_nxt = nv5_r[DW-1] || ((DW+1)'(det5_r) < uv_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    par6_r  <= par5_r;
    ubad6_r <= ubad_nxt;
    vbad6_r <= vbad_nxt;
    nt6_r   <= nt5_r;
    det6_r  <= det5_r[DB-1:0];
    nu6_r   <= nu5_r[DB-1:0];
    nv6_r   <= nv5_r[DB-1:0];
    tll_r   <= tl5_r * signed'({1'b0, det5_r[DL-1:0]});
    tlh_r   <= tl5_r * signed'({1'b0, det5_r[DB-1:DL]});
    tul_r   <= tu5_r * signed'({1'b0, det5_r[DL-1:0]});
    tuh_r   <= tu5_r * signed'({1'b0, det5_r[DB-1:DL]});
  end

  // stage 7: window test and final reason
  logic                 v7_r;
  rti_pkg::rti_tag_t    tag7_r;
  logic [DB-1:0]        det7_r, tmag7_r, nu7_r, nv7_r;

  logic signed [CW-1:0] tld, tud, lhs;
  logic signed [DW-1:0] ntabs;
  rti_pkg::rti_tag_t    tag_nxt;

  always_comb begin
    tld   = (CW'(tlh_r) <<< DL) + CW'(tll_r);
    tud   = (CW'(tuh_r) <<< DL) + CW'(tul_r);
    lhs   = CW'(nt6_r) <<< FRAC_BITS;
    ntabs = nt6_r[DW-1] ? -nt6_r : nt6_r;
    tag_nxt.t_neg = nt6_r[DW-1];
    priority if (par6_r) begin
      tag_nxt.reason = rti_pkg::RSN_PARALLEL;
    end else if (ubad6_r) begin
      tag_nxt.reason = rti_pkg::RSN_U_OUT;
    end else if (vbad6_r) begin
      tag_nxt.reason = rti_pkg::RSN_V_OUT;
    end else if (!((tld < lhs) && (lhs < tud))) begin
      tag_nxt.reason = rti_pkg::RSN_T_OUT;
    end else begin
      tag_nxt.reason = rti_pkg::RSN_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    tag7_r  <= tag_nxt;
    det7_r  <= det6_r;
    tmag7_r <= ntabs[DB-1:0];
    nu7_r   <= nu6_r;
    nv7_r   <= nv6_r;
  end

  assign push_valid = v7_r;
  assign push_tag   = tag7_r;
  assign push_det   = det7_r;
  assign push_tmag  = tmag7_r;
  assign push_nu    = nu7_r;
  assign push_nv    = nv7_r;

endmodule

>>> sv/rti_queue.sv
// Short word queue between the front and back pipelines; drains one word per cycle.
module rti_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rti_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, rd_r, wr_nxt, rd_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    rd_nxt  = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    cnt_nxt = cnt_r + NW'(push) - NW'(pop_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_nxt;
      end
      if (pop_valid) begin
        rd_r <= rd_nxt;
      end
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

>>> sv/rti_back.sv
// Back pipeline: three restoring dividers, one quotient bit per stage, and the result register.
module rti_back #(
  parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  rti_pkg::rti_tag_t                 in_tag,
  input  logic [3*COORD_BITS+2:0]           in_det,
  input  logic [3*COORD_BITS+2:0]           in_tmag,
  input  logic [3*COORD_BITS+2:0]           in_nu,
  input  logic [3*COORD_BITS+2:0]           in_nv,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [rti_pkg::REASON_BITS-1:0]   out_reason,
  output logic signed [COORD_BITS-1:0]      out_hit_distance,
  output logic [rti_pkg::BARY_BITS-1:0]     out_bary_u,
  output logic [rti_pkg::BARY_BITS-1:0]     out_bary_v
);

  localparam int C  = COORD_BITS;
  localparam int DB = 3 * C + 3;
  localparam int QB = (C > rti_pkg::BARY_BITS) ? C : rti_pkg::BARY_BITS;
  localparam int NW = DB + QB;

  logic              vld_r [QB+1];
  rti_pkg::rti_tag_t tag_r [QB+1];
  logic [DB-1:0]     dv_r  [QB+1];
  logic [NW-1:0]     rt_r  [QB+1];
  logic [NW-1:0]     ru_r  [QB+1];
  logic [NW-1:0]     rv_r  [QB+1];
  logic [QB-1:0]     qt_r  [QB+1];
  logic [QB-1:0]     qu_r  [QB+1];
  logic [QB-1:0]     qv_r  [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    tag_r[0] <= in_tag;
    dv_r[0]  <= in_det;
    rt_r[0]  <= NW'(in_tmag) << FRAC_BITS;
    ru_r[0]  <= NW'(in_nu) << rti_pkg::BARY_SHIFT;
    rv_r[0]  <= NW'(in_nv) << rti_pkg::BARY_SHIFT;
    qt_r[0]  <= '0;
    qu_r[0]  <= '0;
    qv_r[0]  <= '0;
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [NW-1:0] dk;
    logic          ge_t, ge_u, ge_v;

    assign dk   = NW'(dv_r[j]) << K;
    assign ge_t = (rt_r[j] >= dk);
    assign ge_u = (ru_r[j] >= dk);
    assign ge_v = (rv_r[j] >= dk);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
      tag_r[j+1] <= tag_r[j];
      dv_r[j+1]  <= dv_r[j];
      rt_r[j+1]  <= ge_t ? rt_r[j] - dk : rt_r[j];
      ru_r[j+1]  <= ge_u ? ru_r[j] - dk : ru_r[j];
      rv_r[j+1]  <= ge_v ? rv_r[j] - dk : rv_r[j];
      qt_r[j+1]  <= qt_r[j] | (QB'(ge_t) << K);
      qu_r[j+1]  <= qu_r[j] | (QB'(ge_u) << K);
      qv_r[j+1]  <= qv_r[j] | (QB'(ge_v) << K);
    end
  end

  logic                                  hit_nxt;
  logic [C-1:0]                          dist_nxt;
  logic                                  valid_r, hit_r;
  logic [rti_pkg::REASON_BITS-1:0]       reason_r;
  logic [C-1:0]                          dist_r;
  logic [rti_pkg::BARY_BITS-1:0]         u_r, v_r;

  always_comb begin
    hit_nxt  = (tag_r[QB].reason == rti_pkg::RSN_HIT);
    dist_nxt = tag_r[QB].t_neg ? (C'(0) - qt_r[QB][C-1:0]) : qt_r[QB][C-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld_r[QB];
    end
    hit_r    <= hit_nxt;
    reason_r <= tag_r[QB].reason;
    dist_r   <= hit_nxt ? dist_nxt : '0;
    u_r      <= hit_nxt ? qu_r[QB][rti_pkg::BARY_BITS-1:0] : '0;
    v_r      <= hit_nxt ? qv_r[QB][rti_pkg::BARY_BITS-1:0] : '0;
  end

  assign out_valid        = valid_r;
  assign out_hit          = hit_r;
  assign out_reason       = reason_r;
  assign out_hit_distance = signed'(dist_r);
  assign out_bary_u       = u_r;
  assign out_bary_v       = v_r;

endmodule

>>> sv/ray_triangle_intersect.sv
// Top level of the ray/triangle intersection block: config register, credit count, front, queue, back.
//
//  channel  | handshake              | word
//  ---------+------------------------+-----------------------------------------------
//  input    | start / busy           | in_ray_origin .. in_vertex_c, in_t_lower/upper
//  result   | out_valid (strobe)     | out_hit, out_reason, out_hit_distance, out_bary_u/v
//  config   | cfg_we                 | cfg_wdata (det_epsilon)
//
//  One word per cycle sustained while busy stays low; the path runs through 7 front stages, the queue,
//  the back input register, max(COORD_BITS, 17) divider stages and the result register.
//  The divider pipeline, one quotient bit per stage, sets the latency.
//  rst_n is synchronous; det_epsilon resets to 1 and all pipelines empty.
//  busy rises only when the queue credits run out; results cannot be held off.
module ray_triangle_intersect #(
  parameter int COORD_BITS  = rti_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = rti_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [3*COORD_BITS-1:0]           in_ray_origin,
  input  logic [3*COORD_BITS-1:0]           in_ray_direction,
  input  logic signed [COORD_BITS-1:0]      in_t_lower,
  input  logic signed [COORD_BITS-1:0]      in_t_upper,
  input  logic [3*COORD_BITS-1:0]           in_vertex_a,
  input  logic [3*COORD_BITS-1:0]           in_vertex_b,
  input  logic [3*COORD_BITS-1:0]           in_vertex_c,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [rti_pkg::REASON_BITS-1:0]   out_reason,
  output logic signed [COORD_BITS-1:0]      out_hit_distance,
  output logic [rti_pkg::BARY_BITS-1:0]     out_bary_u,
  output logic [rti_pkg::BARY_BITS-1:0]     out_bary_v,
  input  logic                              cfg_we,
  input  logic [rti_pkg::EPS_BITS-1:0]      cfg_wdata
);

  localparam int DB = 3 * COORD_BITS + 3;
  localparam int TW = $bits(rti_pkg::rti_tag_t);
  localparam int QW = TW + 4 * DB;
  localparam int UW = $clog2(QUEUE_DEPTH + 1);

  logic [rti_pkg::EPS_BITS-1:0] eps_r;
  logic [UW-1:0]                used_r, used_nxt;
  logic                         accept;

  logic              f_valid;
  rti_pkg::rti_tag_t f_tag;
  logic [DB-1:0]     f_det, f_tmag, f_nu, f_nv;

  logic              q_valid;
  logic [QW-1:0]     q_data;
  rti_pkg::rti_tag_t b_tag;

  assign busy   = (used_r == UW'(QUEUE_DEPTH)) && !q_valid;
  assign accept = start && !busy;

  always_comb begin
    used_nxt = used_r + UW'(accept) - UW'(q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= rti_pkg::EPS_RESET;
      used_r <= '0;
    end else begin
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
      used_r <= used_nxt;
    end
  end

  rti_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (accept),
    .ray_origin    (in_ray_origin),
    .ray_direction (in_ray_direction),
    .t_lower       (in_t_lower),
    .t_upper       (in_t_upper),
    .vertex_a      (in_vertex_a),
    .vertex_b      (in_vertex_b),
    .vertex_c      (in_vertex_c),
    .det_eps       (eps_r),
    .push_valid    (f_valid),
    .push_tag      (f_tag),
    .push_det      (f_det),
    .push_tmag     (f_tmag),
    .push_nu       (f_nu),
    .push_nv       (f_nv)
  );

  rti_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data ({f_tag, f_det, f_tmag, f_nu, f_nv}),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  assign b_tag = q_data[QW-1 -: TW];

  rti_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (q_valid),
    .in_tag           (b_tag),
    .in_det           (q_data[4*DB-1 -: DB]),
    .in_tmag          (q_data[3*DB-1 -: DB]),
    .in_nu            (q_data[2*DB-1 -: DB]),
    .in_nv            (q_data[DB-1:0]),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_reason       (out_reason),
    .out_hit_distance (out_hit_distance),
    .out_bary_u       (out_bary_u),
    .out_bary_v       (out_bary_v)
  );

endmodule
